// ----- design/pde_pkg.sv -----
package pde_pkg;

   localparam int MAX_DEGREE = 7;
   localparam int FRAC_BITS  = 16;
   localparam int NUM_COEFF  = 8;
   localparam int COEFF_AW   = 3;
   localparam int DATA_W     = 32;
   localparam int ORDER_W    = 3;
   localparam int FAC_W      = 13;
   localparam int PROD_D_W   = DATA_W + FAC_W + 1;
   localparam int CSR_AW     = 5;

   localparam logic signed [63:0] ROUND_HALF = (64'sd1 <<< FRAC_BITS) >>> 1;
   localparam logic signed [63:0] S32_MAX    = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN    = -64'sd2147483648;

   typedef struct packed {
      logic signed [DATA_W-1:0] point;
      logic [ORDER_W-1:0]       order;
      logic                     zero;
   } pde_item_type;

   typedef struct packed {
      logic                en;
      logic [COEFF_AW-1:0] addr;
   } coeff_rd_type;

   typedef struct packed {
      logic                     ovf;
      logic signed [DATA_W-1:0] value;
   } sat_type;

   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type r;
      if (v > S32_MAX) begin
         r.ovf   = 1'b1;
         r.value = S32_MAX[DATA_W-1:0];
      end else if (v < S32_MIN) begin
         r.ovf   = 1'b1;
         r.value = S32_MIN[DATA_W-1:0];
      end else begin
         r.ovf   = 1'b0;
         r.value = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // falling factorial (i+k)!/i!, indexed by {k, i}
   function automatic logic [NUM_COEFF*NUM_COEFF*FAC_W-1:0] fac_build();
      logic [NUM_COEFF*NUM_COEFF*FAC_W-1:0] t;
      int f;
      t = '0;
      for (int k = 0; k < NUM_COEFF; k++) begin
         for (int i = 0; i < NUM_COEFF; i++) begin
            f = 1;
            for (int j = i + 1; j <= i + k; j++) begin
               f = f * j;
            end
            t[(k*NUM_COEFF+i)*FAC_W +: FAC_W] = FAC_W'(f);
         end
      end
      return t;
   endfunction

   localparam logic [NUM_COEFF*NUM_COEFF*FAC_W-1:0] FAC_TABLE = fac_build();

   function automatic logic [FAC_W-1:0] fac_lookup(input logic [ORDER_W-1:0] k,
                                                   input logic [COEFF_AW-1:0] i);
      return FAC_TABLE[int'({k, i})*FAC_W +: FAC_W];
   endfunction

endpackage

// ----- design/pde_front.sv -----
module pde_front
   import pde_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [DATA_W-1:0]        req_tdata,   // [31:0] point
   input  logic [ORDER_W-1:0]       req_tuser,   // [2:0] deriv_order
   output logic                     item_valid,
   output pde_item_type             item,
   input  logic                     item_pop
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   pde_item_type       queue_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               push;
   pde_item_type       new_item;

   assign req_tready = (count_ff != (PTR_W+1)'(DEPTH));
   assign push       = req_tvalid & req_tready;
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      new_item.point = $signed(req_tdata);
      new_item.order = req_tuser;
      new_item.zero  = (int'(req_tuser) > MAX_DEGREE);
   end

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = item_pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !item_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && item_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ----- design/pde_coeff_regs.sv -----
module pde_coeff_regs
   import pde_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CSR_AW-1:0]    csr_paddr,
   input  logic [DATA_W-1:0]    csr_pwdata,
   output logic [DATA_W-1:0]    csr_prdata,
   input  coeff_rd_type         rd,
   output logic [DATA_W-1:0]    rd_data
);

   logic [DATA_W-1:0]    coeff_mem_ff [NUM_COEFF];
   logic [NUM_COEFF-1:0] valid_ff;
   logic [DATA_W-1:0]    prdata_ff;
   logic [DATA_W-1:0]    rd_data_ff;
   logic [COEFF_AW-1:0]  csr_idx;
   logic                 wr_en;

   assign csr_idx    = csr_paddr[CSR_AW-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = prdata_ff;
   assign rd_data    = rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[csr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         coeff_mem_ff[csr_idx] <= csr_pwdata;
      end
      if (csr_psel) begin
         prdata_ff <= valid_ff[csr_idx] ? coeff_mem_ff[csr_idx] : '0;
      end
      if (rd.en) begin
         rd_data_ff <= valid_ff[rd.addr] ? coeff_mem_ff[rd.addr] : '0;
      end
   end

endmodule

// ----- design/pde_engine.sv -----
module pde_engine
   import pde_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  pde_item_type         item,
   output logic                 item_pop,
   output coeff_rd_type         coeff_rd,
   input  logic [DATA_W-1:0]    coeff_data,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_W-1:0]    rsp_tdata,   // [31:0] value
   output logic                 rsp_tuser    // [0] overflow
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_INIT = 6'b000010,
      ST_SEED = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_ACC  = 6'b010000,
      ST_DONE = 6'b100000
   } eng_state_type;

   eng_state_type               state_ff, state_in;
   logic signed [DATA_W-1:0]    x_ff, x_in;
   logic [ORDER_W-1:0]          k_ff, k_in;
   logic [COEFF_AW-1:0]         idx_ff, idx_in;
   logic signed [63:0]          prod_x_ff, prod_x_in;
   logic signed [PROD_D_W-1:0]  prod_d_ff, prod_d_in;
   logic signed [DATA_W-1:0]    acc_ff, acc_in;
   logic                        ovf_ff, ovf_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]           rsp_value_ff, rsp_value_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;

   logic [FAC_W-1:0]            fac;
   logic signed [PROD_D_W-1:0]  prod_d_new;
   logic signed [63:0]          rnd;
   logic signed [63:0]          sum;
   sat_type                     d_sat, p_sat, s_sat;
   logic                        out_free;

   assign fac        = fac_lookup(k_ff, idx_ff);
   assign prod_d_new = $signed(coeff_data) * $signed({1'b0, fac});
   assign d_sat      = sat32({{(64-PROD_D_W){prod_d_ff[PROD_D_W-1]}}, prod_d_ff});
   assign rnd        = (prod_x_ff + ROUND_HALF) >>> FRAC_BITS;
   assign p_sat      = sat32(rnd);
   assign sum        = {{(64-DATA_W){p_sat.value[DATA_W-1]}}, p_sat.value}
                     + {{(64-DATA_W){d_sat.value[DATA_W-1]}}, d_sat.value};
   assign s_sat      = sat32(sum);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign item_pop   = (state_ff == ST_IDLE) && item_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      k_in          = k_ff;
      idx_in        = idx_ff;
      prod_x_in     = prod_x_ff;
      prod_d_in     = prod_d_ff;
      acc_in        = acc_ff;
      ovf_in        = ovf_ff;
      coeff_rd.en   = 1'b0;
      coeff_rd.addr = COEFF_AW'(idx_ff + k_ff - 1'b1);
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               x_in   = item.point;
               k_in   = item.order;
               idx_in = COEFF_AW'(MAX_DEGREE - int'(item.order));
               acc_in = '0;
               ovf_in = 1'b0;
               if (item.zero) begin
                  state_in = ST_DONE;
               end else begin
                  coeff_rd.en   = 1'b1;
                  coeff_rd.addr = COEFF_AW'(MAX_DEGREE);
                  state_in      = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            prod_d_in = prod_d_new;
            state_in  = ST_SEED;
         end
         ST_SEED: begin
            acc_in = d_sat.value;
            ovf_in = ovf_ff | d_sat.ovf;
            if (idx_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               idx_in      = idx_ff - 1'b1;
               coeff_rd.en = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_x_in = acc_ff * x_ff;
            prod_d_in = prod_d_new;
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            acc_in = s_sat.value;
            ovf_in = ovf_ff | p_sat.ovf | d_sat.ovf | s_sat.ovf;
            if (idx_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               idx_in      = idx_ff - 1'b1;
               coeff_rd.en = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = acc_ff;
               rsp_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      k_ff         <= k_in;
      idx_ff       <= idx_in;
      prod_x_ff    <= prod_x_in;
      prod_d_ff    <= prod_d_in;
      acc_ff       <= acc_in;
      ovf_ff       <= ovf_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

endmodule

// ----- design/polynomial_derivative_evaluator.sv -----
// Evaluates the k-th derivative (k = 0 gives the polynomial itself) of a degree-7
// polynomial held in eight signed Q16.16 coefficient registers, at the point x
// of each request beat, by Horner's rule, with one 32x32 multiply of the
// accumulator by x and a separate one of each coefficient by its factorial. Every
// intermediate saturates to 32 bits and any clamp sets the overflow bit of the
// response. Each Horner step registers the product in ST_MUL, then rounds,
// saturates and adds it in ST_ACC. A beat leaves the two-beat input queue only
// when the engine is idle, so the engine takes no new beat until the last one
// has loaded the response register. Coefficient reads through the CSR port
// return the written value; coefficients reset to zero.
module polynomial_derivative_evaluator
   import pde_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_W-1:0]    req_tdata,   // [31:0] point
   input  logic [ORDER_W-1:0]   req_tuser,   // [2:0] deriv_order
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_W-1:0]    rsp_tdata,   // [31:0] value
   output logic                 rsp_tuser,   // [0] overflow
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CSR_AW-1:0]    csr_paddr,
   input  logic [DATA_W-1:0]    csr_pwdata,
   output logic [DATA_W-1:0]    csr_prdata,
   output logic                 csr_pready
);

   logic              item_valid;
   pde_item_type      item;
   logic              item_pop;
   coeff_rd_type      coeff_rd;
   logic [DATA_W-1:0] coeff_data;

   assign csr_pready = 1'b1;

   pde_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   pde_coeff_regs u_coeff (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .rd          (coeff_rd),
      .rd_data     (coeff_data)
   );

   pde_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .coeff_rd   (coeff_rd),
      .coeff_data (coeff_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- design/pde_checker.sv -----
module pde_checker
   import pde_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [DATA_W-1:0]    rsp_tdata,
   input  logic                 rsp_tuser
);

   logic [2:0] pending_ff, pending_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_tvalid & req_tready;
   assign rsp_beat = rsp_tvalid & rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 1'b1;
      end else if (!req_beat && rsp_beat) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response dropped or changed while stalled");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 3'd0)
      else $error("response beat without an outstanding request");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd4)
      else $error("more requests in flight than the queue and engine hold");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 3'd4 |-> !req_tready)
      else $error("request accepted with queue, engine and output all occupied");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid straight after reset");

endmodule

bind polynomial_derivative_evaluator pde_checker u_pde_checker (.*);

// ----- bench/polynomial_derivative_evaluator_test.sv -----
module polynomial_derivative_evaluator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pde_pkg::*;

   localparam int CLOCK_PERIOD    = 12;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RUN_LIMIT_NS    = 6_000_000;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int REPORT_LIMIT    = 40;
   localparam int RANDOM_SETS     = 6;
   localparam int POINTS_PER_SET  = 100;
   localparam int BURST_POINTS    = 24;

   localparam int UNIT = 1 << FRAC_BITS;
   localparam logic signed [DATA_W-1:0] WORD_TOP    = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] WORD_BOTTOM = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] ONE_FIX     = 32'sh0001_0000;
   localparam logic signed [DATA_W-1:0] HALF_FIX    = 32'sh0000_8000;

   localparam longint CLAMP_HIGH = 64'sd2147483647;
   localparam longint CLAMP_LOW  = -64'sd2147483648;
   localparam longint ROUND_BIAS = (longint'(1) << FRAC_BITS) >> 1;

   typedef enum logic [COEFF_AW-1:0] {
      REG_COEFF_0, REG_COEFF_1, REG_COEFF_2, REG_COEFF_3,
      REG_COEFF_4, REG_COEFF_5, REG_COEFF_6, REG_COEFF_7
   } coeff_index_type;

   typedef enum int {
      COEFF_SMALL, COEFF_FULL, COEFF_MIXED
   } coeff_style_type;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     overflow;
   } derivative_result_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_tvalid  = 1'b0;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata   = '0;
   logic [ORDER_W-1:0]   req_tuser   = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready  = 1'b0;
   logic [DATA_W-1:0]    rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_psel    = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]    csr_paddr   = '0;
   logic [DATA_W-1:0]    csr_pwdata  = '0;
   logic [DATA_W-1:0]    csr_prdata;
   logic                 csr_pready;

   logic signed [DATA_W-1:0] coeff_shadow [NUM_COEFF] = '{default: '0};
   derivative_result_type    expected_derivatives [$];

   bit steady_flow;
   bit hold_off_asked;
   int mismatches;
   int beats_sent;
   int results_checked;
   int saturated_results;
   int input_stall_cycles;
   int coeff_sets;

   polynomial_derivative_evaluator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // [31:0] point
      .req_tuser   (req_tuser),   // [2:0] deriv_order
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // [31:0] value
      .rsp_tuser   (rsp_tuser),   // [0] overflow
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin : clock_gen
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic longint clamp32(input longint v, inout logic sat);
      if (v > CLAMP_HIGH) begin
         sat = 1'b1;
         return CLAMP_HIGH;
      end
      if (v < CLAMP_LOW) begin
         sat = 1'b1;
         return CLAMP_LOW;
      end
      return v;
   endfunction

   function automatic derivative_result_type eval_derivative(
         input logic signed [DATA_W-1:0] x, input logic [ORDER_W-1:0] k);
      derivative_result_type r;
      longint acc;
      longint scaled;
      longint prod;
      longint fac;
      logic sat;
      int top;
      acc = 0;
      sat = 1'b0;
      top = MAX_DEGREE - int'(k);
      for (int i = top; i >= 0; i--) begin
         fac = 1;
         for (int j = i + 1; j <= i + int'(k); j++) begin
            fac = fac * j;
         end
         scaled = clamp32(longint'(coeff_shadow[i + int'(k)]) * fac, sat);
         if (i == top) begin
            acc = scaled;
         end else begin
            prod = clamp32((acc * longint'(x) + ROUND_BIAS) >>> FRAC_BITS, sat);
            acc  = clamp32(prod + scaled, sat);
         end
      end
      r.value    = acc[DATA_W-1:0];
      r.overflow = sat;
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return WORD_TOP;
         1: return WORD_BOTTOM;
         2: return '0;
         3: return ONE_FIX;
         default: return -ONE_FIX;
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] random_point();
      case ($urandom_range(0, 9))
         0: return pick_extreme();
         1, 2, 3: return $urandom();
         default: return $urandom_range(0, 6 * UNIT) - 3 * UNIT;
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] random_coeff(input coeff_style_type style);
      case (style)
         COEFF_SMALL: return $urandom_range(0, 8 * UNIT) - 4 * UNIT;
         COEFF_FULL: return $urandom();
         default: begin
            case ($urandom_range(0, 3))
               0: return pick_extreme();
               1: return random_coeff(COEFF_FULL);
               default: return random_coeff(COEFF_SMALL);
            endcase
         end
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%0t mismatch: %s", $realtime, what);
   endtask

   task automatic csr_write(input coeff_index_type idx, input logic [DATA_W-1:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(4 * int'(idx));
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      coeff_shadow[int'(idx)] = v;
      @(negedge clock);
   endtask

   task automatic csr_idle();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic load_set(input logic signed [DATA_W-1:0] c [NUM_COEFF]);
      for (int i = 0; i < NUM_COEFF; i++) begin
         csr_write(coeff_index_type'(i), c[i]);
      end
      csr_idle();
      coeff_sets++;
   endtask

   task automatic load_all(input logic signed [DATA_W-1:0] v);
      logic signed [DATA_W-1:0] c [NUM_COEFF];
      c = '{default: v};
      load_set(c);
   endtask

   task automatic load_random(input coeff_style_type style);
      logic signed [DATA_W-1:0] c [NUM_COEFF];
      for (int i = 0; i < NUM_COEFF; i++) begin
         c[i] = random_coeff(style);
      end
      load_set(c);
   endtask

   task automatic send_point(input logic signed [DATA_W-1:0] x, input logic [ORDER_W-1:0] k);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      req_tuser  <= k;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      expected_derivatives.push_back(eval_derivative(x, k));
      beats_sent++;
      @(negedge clock);
   endtask

   // drop valid, then hold until every predicted beat has come back
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_derivatives.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_reset_coeffs();
      send_point(WORD_TOP, 3'd0);
      send_point(WORD_BOTTOM, 3'd7);
      settle_block();
   endtask

   task automatic test_saturation_extremes();
      load_all(WORD_TOP);
      for (int k = 0; k <= MAX_DEGREE; k++) begin
         send_point(WORD_TOP, ORDER_W'(k));
      end
      send_point('0, 3'd0);
      settle_block();
      load_all(WORD_BOTTOM);
      send_point(WORD_BOTTOM, 3'd0);
      send_point(WORD_BOTTOM, 3'd3);
      send_point(WORD_BOTTOM, 3'd7);
      settle_block();
   endtask

   task automatic test_rounding_ties();
      load_all('0);
      @(negedge clock);
      csr_write(REG_COEFF_1, 32'sd1);
      csr_idle();
      send_point(HALF_FIX, 3'd0);
      send_point(-HALF_FIX, 3'd0);
      settle_block();
      csr_write(REG_COEFF_1, -32'sd1);
      csr_idle();
      send_point(HALF_FIX, 3'd0);
      send_point(-HALF_FIX, 3'd0);
      settle_block();
   endtask

   task automatic test_unit_coeffs();
      load_all(ONE_FIX);
      for (int k = 0; k <= MAX_DEGREE; k++) begin
         send_point(ONE_FIX, ORDER_W'(k));
      end
      settle_block();
   endtask

   task automatic test_random_sets();
      for (int s = 0; s < RANDOM_SETS; s++) begin
         load_random(coeff_style_type'(s % 3));
         steady_flow = (s == 4);
         for (int n = 0; n < POINTS_PER_SET; n++) begin
            send_point(random_point(), ORDER_W'($urandom_range(0, MAX_DEGREE)));
         end
         settle_block();
         steady_flow = 1'b0;
      end
   endtask

   task automatic test_output_hold_off();
      load_random(COEFF_MIXED);
      steady_flow    = 1'b1;
      hold_off_asked = 1'b1;
      for (int n = 0; n < BURST_POINTS; n++) begin
         send_point(random_point(), ORDER_W'($urandom_range(0, MAX_DEGREE)));
      end
      steady_flow = 1'b0;
      settle_block();
   endtask

   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_asked) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_asked = 1'b0;
            rsp_tready <= 1'b1;
         end else if (steady_flow) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: rsp_tready <= 1'b1;
               19: begin
                  rsp_tready <= 1'b0;
                  stall_left = $urandom_range(10, 40) - 1;
               end
               default: begin
                  rsp_tready <= 1'b0;
                  stall_left = $urandom_range(1, 3) - 1;
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin : result_check
      derivative_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready === 1'b0) input_stall_cycles++;
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            results_checked++;
            if (rsp_tuser === 1'b1) saturated_results++;
            if (expected_derivatives.size() == 0) begin
               note_mismatch($sformatf("result beat %h with nothing outstanding", rsp_tdata));
            end else begin
               want = expected_derivatives.pop_front();
               if (rsp_tdata !== want.value)
                  note_mismatch($sformatf("value %h, predicted %h", rsp_tdata, want.value));
               if (rsp_tuser !== want.overflow)
                  note_mismatch($sformatf("overflow %b, predicted %b (value %h)",
                                          rsp_tuser, want.overflow, want.value));
            end
         end
      end
   end

   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("run limit reached with %0d results outstanding", expected_derivatives.size());
      $display("polynomial_derivative_evaluator_test: FAIL");
      $finish;
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_coeffs();
      test_saturation_extremes();
      test_rounding_ties();
      test_unit_coeffs();
      test_random_sets();
      test_output_hold_off();
      req_tvalid <= 1'b0;
      for (int c = 0; c < DRAIN_LIMIT && expected_derivatives.size() != 0; c++) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_derivatives.size() != 0)
         note_mismatch($sformatf("%0d predicted results never arrived",
                                 expected_derivatives.size()));
      $display("covered %0d beats, orders 0 to %0d, over %0d coefficient sets; %0d saturated",
               beats_sent, MAX_DEGREE, coeff_sets, saturated_results);
      $display("%0d results checked; output held off %0d cycles, input stalled %0d cycles",
               results_checked, HOLD_OFF_CYCLES, input_stall_cycles);
      if (mismatches == 0) begin
         $display("polynomial_derivative_evaluator_test: PASS");
      end else begin
         $display("polynomial_derivative_evaluator_test: FAIL");
      end
      $finish;
   end

endmodule
